/* design/rpq_pkg.sv */
package rpq_pkg;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned TAG_W = 32;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_HANDLE = 2'd1,
    OP_PEEK   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CLS_HIGH = 1'b0,
    CLS_LOW  = 1'b1
  } class_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // one stored request
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // occupancy flags of one fifo
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_flags_t;

  // command control from the queue update to the fifo pointer keeper
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  // result fields held while the memory read completes
  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] request_id;
    class_t          out_class;
    logic            from_mem;
  } pend_t;

endpackage

/* design/rpq_req_if.sv */
interface rpq_req_if;
  import rpq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic             priority_class;
  logic [TAG_W-1:0] issue_tag;

  modport source (output valid, output opcode, output priority_class, output issue_tag,
                  input ready);
  modport sink (input valid, input opcode, input priority_class, input issue_tag,
                output ready);
endinterface

/* design/rpq_rsp_if.sv */
interface rpq_rsp_if;
  import rpq_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  request_id;
  logic             out_class;
  logic [TAG_W-1:0] out_issue_tag;

  modport source (output valid, output status, output request_id, output out_class,
                  output out_issue_tag, input ready);
  modport sink (input valid, input status, input request_id, input out_class,
                input out_issue_tag, output ready);
endinterface

/* design/rpq_ram.sv */
module rpq_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/rpq_fifo_ctl.sv */
module rpq_fifo_ctl #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rpq_pkg::fifo_cmd_t       cmd,
  output logic [$clog2(DEPTH)-1:0] head,
  output logic [$clog2(DEPTH)-1:0] tail,
  output rpq_pkg::fifo_flags_t     flags
);
  import rpq_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] pos);
    advance = (pos == LAST_IDX) ? '0 : pos + IDX_W'(1);
  endfunction

  assign flags.empty = (count == '0);
  assign flags.full  = (count == FULL_CNT);

  // the caller only pushes when not full and only pops when not empty
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail <= advance(tail);
      end
      if (cmd.pop) begin
        head <= advance(head);
      end
      if (cmd.push && !cmd.pop) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop && !cmd.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* design/two_level_priority_request_queue_unit.sv */
// Two-class strict-priority request queue.
// req channel: one command beat (opcode, priority_class, issue_tag). Submit
// stores the request in the high or low fifo and hands out the running id;
// the id advances even when the fifo is full. Handle pops the oldest high
// request, else the oldest low one; peek returns the same without removing.
// rsp channel: exactly one result beat per command (status, request_id,
// out_class, out_issue_tag).
// Each command passes the idle state and then the read state: the accept cycle
// updates pointers, counts, the id counter and issues the fifo memory write or
// read, the read state takes the registered read data into the output register.
// No new command is accepted until the previous one is in the output register.
// rsp valid is registered: it rises with the output register load in the read state.
// The output register lets a new command be accepted while the previous
// result waits; if the receiver stalls, the second command holds in the read
// stage and req ready stays low until the output register frees up.
// Reset (rst, synchronous) empties both fifos, sets the next id to 1 and
// drops rsp valid. Memory contents are not cleared and need no clearing pass.
module two_level_priority_request_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input logic clk,
  input logic rst,
  rpq_req_if.sink   req,
  rpq_rsp_if.source rsp
);
  import rpq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENT_W = $bits(entry_t);

  state_t state;
  state_t state_next;

  logic [ID_W-1:0] next_id;
  pend_t           pend;
  class_t          pend_sel;

  fifo_cmd_t   hi_cmd;
  fifo_cmd_t   lo_cmd;
  fifo_flags_t hi_flags;
  fifo_flags_t lo_flags;
  logic [IDX_W-1:0] hi_head;
  logic [IDX_W-1:0] hi_tail;
  logic [IDX_W-1:0] lo_head;
  logic [IDX_W-1:0] lo_tail;

  logic   hi_re;
  logic   lo_re;
  entry_t wr_entry;
  entry_t hi_rdata;
  entry_t lo_rdata;
  entry_t rd_entry;

  logic   accept;
  logic   load_out;
  pend_t  pend_next;
  class_t sel_next;

  logic             out_valid;
  status_t          out_status;
  logic [ID_W-1:0]  out_id;
  class_t           out_cls;
  logic [TAG_W-1:0] out_tag;

  // ---------------- control fsm
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_READ: load_out  = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = req.valid && req.ready;

  // ---------------- command decode
  always_comb begin
    hi_cmd    = '0;
    lo_cmd    = '0;
    hi_re     = 1'b0;
    lo_re     = 1'b0;
    pend_next = '{status: STAT_EMPTY, request_id: '0, out_class: CLS_HIGH, from_mem: 1'b0};
    sel_next  = CLS_HIGH;
    case (opcode_t'(req.opcode))
      OP_SUBMIT: begin
        pend_next.request_id = next_id;
        pend_next.out_class  = class_t'(req.priority_class);
        if (req.priority_class == CLS_LOW) begin
          pend_next.status = lo_flags.full ? STAT_FULL : STAT_OK;
          lo_cmd.push      = accept && !lo_flags.full;
        end else begin
          pend_next.status = hi_flags.full ? STAT_FULL : STAT_OK;
          hi_cmd.push      = accept && !hi_flags.full;
        end
      end
      OP_HANDLE, OP_PEEK: begin
        if (!hi_flags.empty) begin
          pend_next.status   = STAT_OK;
          pend_next.from_mem = 1'b1;
          hi_re              = accept;
          hi_cmd.pop         = accept && (req.opcode == OP_HANDLE);
        end else if (!lo_flags.empty) begin
          pend_next.status    = STAT_OK;
          pend_next.out_class = CLS_LOW;
          pend_next.from_mem  = 1'b1;
          sel_next            = CLS_LOW;
          lo_re               = accept;
          lo_cmd.pop          = accept && (req.opcode == OP_HANDLE);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= ID_W'(1);
    end else if (accept && req.opcode == OP_SUBMIT) begin
      next_id <= next_id + ID_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend     <= pend_next;
      pend_sel <= sel_next;
    end
  end

  // ---------------- fifo pointers and memories
  assign wr_entry = '{id: next_id, tag: req.issue_tag};

  rpq_fifo_ctl #(.DEPTH(QUEUE_DEPTH)) u_hi_ctl (
    .clk   (clk),
    .rst   (rst),
    .cmd   (hi_cmd),
    .head  (hi_head),
    .tail  (hi_tail),
    .flags (hi_flags)
  );

  rpq_fifo_ctl #(.DEPTH(QUEUE_DEPTH)) u_lo_ctl (
    .clk   (clk),
    .rst   (rst),
    .cmd   (lo_cmd),
    .head  (lo_head),
    .tail  (lo_tail),
    .flags (lo_flags)
  );

  rpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENT_W)) u_hi_ram (
    .clk   (clk),
    .we    (hi_cmd.push),
    .waddr (hi_tail),
    .wdata (wr_entry),
    .re    (hi_re),
    .raddr (hi_head),
    .rdata (hi_rdata)
  );

  rpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENT_W)) u_lo_ram (
    .clk   (clk),
    .we    (lo_cmd.push),
    .waddr (lo_tail),
    .wdata (wr_entry),
    .re    (lo_re),
    .raddr (lo_head),
    .rdata (lo_rdata)
  );

  // read data stays put until the next read, so a stalled result is safe
  assign rd_entry = (pend_sel == CLS_LOW) ? lo_rdata : hi_rdata;

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= pend.status;
      out_cls    <= pend.out_class;
      out_id     <= pend.from_mem ? rd_entry.id : pend.request_id;
      out_tag    <= pend.from_mem ? rd_entry.tag : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.request_id    = out_id;
  assign rsp.out_class     = out_cls;
  assign rsp.out_issue_tag = out_tag;

endmodule

/* dv/rpq_queue_tracker.sv */
module rpq_queue_tracker
  import rpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic clk,
  input  logic rst,
  rpq_req_if   req,
  rpq_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  request_id;
    class_t           out_class;
    logic [TAG_W-1:0] out_issue_tag;
  } result_t;

  // index 0 is the high class, 1 the low class
  entry_t          class_mem [2][QUEUE_DEPTH];
  int unsigned     rd_pos [2];
  int unsigned     wr_pos [2];
  int unsigned     held [2];
  logic [ID_W-1:0] id_counter;

  result_t expected_results [$];
  int      mismatch_count;

  function automatic result_t queue_step(input logic [1:0] op, input logic cls,
                                         input logic [TAG_W-1:0] tag);
    result_t r;
    int      sel;
    r.status        = STAT_EMPTY;
    r.request_id    = '0;
    r.out_class     = CLS_HIGH;
    r.out_issue_tag = '0;
    if (op == OP_SUBMIT) begin
      sel          = int'(cls);
      r.request_id = id_counter;
      r.out_class  = class_t'(cls);
      id_counter   = id_counter + 1'b1;
      if (held[sel] >= QUEUE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        class_mem[sel][wr_pos[sel]] = '{id: r.request_id, tag: tag};
        wr_pos[sel] = (wr_pos[sel] + 1) % QUEUE_DEPTH;
        held[sel]++;
        r.status = STAT_OK;
      end
    end else if (op == OP_HANDLE || op == OP_PEEK) begin
      sel = (held[0] != 0) ? 0 : (held[1] != 0) ? 1 : -1;
      if (sel >= 0) begin
        r.status        = STAT_OK;
        r.out_class     = class_t'(sel[0]);
        r.request_id    = class_mem[sel][rd_pos[sel]].id;
        r.out_issue_tag = class_mem[sel][rd_pos[sel]].tag;
        if (op == OP_HANDLE) begin
          rd_pos[sel] = (rd_pos[sel] + 1) % QUEUE_DEPTH;
          held[sel]--;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        rd_pos[c] = 0;
        wr_pos[c] = 0;
        held[c]   = 0;
      end
      id_counter = 1;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with none expected: status=%0d id=%0d class=%0d tag=%h",
                     $realtime, rsp.status, rsp.request_id, rsp.out_class, rsp.out_issue_tag);
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status || rsp.request_id !== want.request_id ||
              rsp.out_class !== want.out_class || rsp.out_issue_tag !== want.out_issue_tag)
          begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result mismatch exp status=%0d id=%0d class=%0d tag=%h, got status=%0d id=%0d class=%0d tag=%h",
                       $realtime, want.status, want.request_id, want.out_class,
                       want.out_issue_tag, rsp.status, rsp.request_id, rsp.out_class,
                       rsp.out_issue_tag);
          end
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(queue_step(req.opcode, req.priority_class, req.issue_tag));
    end
    fail_count <= mismatch_count;
    pending    <= expected_results.size();
  end

endmodule

/* dv/tb_two_level_priority_request_queue_unit.sv */
module tb_two_level_priority_request_queue_unit;
  import rpq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = 128;
  localparam logic [1:0]  OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   results_due;

  bit          steady;
  bit          stall_go;

  rpq_req_if req_ch ();
  rpq_rsp_if rsp_ch ();

  two_level_priority_request_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rpq_queue_tracker #(.QUEUE_DEPTH(DEPTH)) tracker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (mismatches),
    .pending    (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // valid stays high across back-to-back beats; only lowered for a gap
  task automatic issue_cmd(input logic [1:0] op, input logic cls, input logic [TAG_W-1:0] tag);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.opcode         <= op;
    req_ch.priority_class <= cls;
    req_ch.issue_tag      <= tag;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // receiver side
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    forever begin
      if (stall_go) begin
        stall_go = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    int submit_pct;
    int wait_cycles;
    logic [1:0] op;
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.opcode         = OP_SUBMIT;
    req_ch.priority_class = CLS_HIGH;
    req_ch.issue_tag      = '0;
    steady                = 1'b0;
    stall_go              = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queues, unused opcode, tag extremes, priority order
    issue_cmd(OP_PEEK,   CLS_HIGH, '1);
    issue_cmd(OP_HANDLE, CLS_LOW,  '1);
    issue_cmd(OP_UNUSED, CLS_LOW,  '1);
    issue_cmd(OP_SUBMIT, CLS_HIGH, '0);
    issue_cmd(OP_SUBMIT, CLS_LOW,  '1);
    issue_cmd(OP_PEEK,   CLS_LOW,  '0);
    issue_cmd(OP_HANDLE, CLS_HIGH, '0);
    issue_cmd(OP_PEEK,   CLS_HIGH, '0);
    issue_cmd(OP_HANDLE, CLS_HIGH, '0);
    issue_cmd(OP_HANDLE, CLS_HIGH, '0);
    issue_cmd(OP_SUBMIT, CLS_LOW,  32'ha5a5_a5a5);
    issue_cmd(OP_SUBMIT, CLS_HIGH, 32'h5a5a_5a5a);
    issue_cmd(OP_UNUSED, CLS_HIGH, '1);
    issue_cmd(OP_HANDLE, CLS_LOW,  '0);
    issue_cmd(OP_HANDLE, CLS_LOW,  '0);
    issue_cmd(OP_SUBMIT, CLS_LOW,  pick_tag());
    issue_cmd(OP_PEEK,   CLS_HIGH, '0);
    issue_cmd(OP_HANDLE, CLS_HIGH, '0);

    // fill both queues past full, then drain the high one and move into low
    steady = 1'b1;
    repeat (DEPTH + 2) issue_cmd(OP_SUBMIT, CLS_HIGH, $urandom);
    repeat (DEPTH + 2) issue_cmd(OP_SUBMIT, CLS_LOW, $urandom);
    repeat (4) issue_cmd(OP_HANDLE, CLS_HIGH, '0);
    repeat (4) issue_cmd(OP_SUBMIT, CLS_HIGH, pick_tag());
    for (int i = 0; i < DEPTH + 24; i++)
      issue_cmd((i % 16 == 0) ? OP_PEEK : OP_HANDLE, logic'($urandom_range(0, 1)), $urandom);

    // random traffic in stretches of varying submit mix
    submit_pct = 50;
    for (int i = 0; i < 200; i++) begin
      if (i % 40 == 0) begin
        r = $urandom_range(0, 2);
        submit_pct = (r == 0) ? 15 : (r == 1) ? 50 : 85;
        steady = ($urandom_range(0, 3) == 0);
      end
      if (i == 100) begin
        steady   = 1'b0;
        stall_go = 1'b1;
      end
      if ($urandom_range(0, 99) < submit_pct) begin
        op = OP_SUBMIT;
      end else begin
        r = $urandom_range(0, 99);
        op = (r < 75) ? OP_HANDLE : (r < 95) ? OP_PEEK : OP_UNUSED;
      end
      issue_cmd(op, logic'($urandom_range(0, 1)), pick_tag());
    end
    req_ch.valid <= 1'b0;
    steady = 1'b0;

    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (results_due != 0 && wait_cycles < 5000);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
design/rpq_pkg.sv
design/rpq_req_if.sv
design/rpq_rsp_if.sv
design/rpq_ram.sv
design/rpq_fifo_ctl.sv
design/two_level_priority_request_queue_unit.sv
dv/rpq_queue_tracker.sv
dv/tb_two_level_priority_request_queue_unit.sv
